// ===== hw/rtl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, constants and token decode for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(DATA_WIDTH);

  localparam int IN_TDATA_W  = 8;
  localparam int TOP_W       = 32;
  localparam int DEPTH_W     = 6;
  localparam int STATUS_W    = 3;
  localparam int OUT_FIELD_W = TOP_W + DEPTH_W + STATUS_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_EXEC,
    S_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_RUN,
    A_FIX
  } alu_state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    data_t   lhs;
    data_t   rhs;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    data_t result;
  } alu_rsp_t;

  function automatic logic is_digit(logic [7:0] t);
    return (t >= CH_0) && (t <= CH_9);
  endfunction

  function automatic logic is_op(logic [7:0] t);
    return t inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  endfunction

  function automatic alu_op_t op_of(logic [7:0] t);
    alu_op_t op;
    case (t)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      default:  op = OP_DIV;
    endcase
    return op;
  endfunction

endpackage

// ===== hw/rtl/pse_serial_alu.sv =====
// ----------------------------------------------------------------------------
// pse_serial_alu
// Bit-serial arithmetic unit: add/sub one bit per cycle, shift-add multiply,
// restoring divide on magnitudes with a final sign fix.
// ----------------------------------------------------------------------------
module pse_serial_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  pse_pkg::alu_req_t  req,
  output pse_pkg::alu_rsp_t  rsp
);
  import pse_pkg::*;

  alu_state_t state_r, state_nxt;
  alu_op_t    op_r, op_nxt;
  data_t      a_r, a_nxt;
  data_t      b_r, b_nxt;
  data_t      acc_r, acc_nxt;
  logic       c_r, c_nxt;
  logic       neg_r, neg_nxt;
  logic       done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic            last;
  data_t           lhs_mag, rhs_mag;
  logic            rhs_bit, sum_bit, carry;
  logic [DATA_WIDTH:0] shifted, trial;
  logic            ge;

  assign last    = (cnt_r == CNT_W'(DATA_WIDTH - 1));
  assign lhs_mag = req.lhs[DATA_WIDTH-1] ? (data_t'(0) - req.lhs) : req.lhs;
  assign rhs_mag = req.rhs[DATA_WIDTH-1] ? (data_t'(0) - req.rhs) : req.rhs;
  assign rhs_bit = b_r[0] ^ (op_r == OP_SUB);
  assign sum_bit = a_r[0] ^ rhs_bit ^ c_r;
  assign carry   = (a_r[0] & rhs_bit) | (a_r[0] & c_r) | (rhs_bit & c_r);
  assign shifted = {acc_r, a_r[DATA_WIDTH-1]};
  assign ge      = (shifted >= {1'b0, b_r});
  assign trial   = shifted - {1'b0, b_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      A_IDLE: begin
        if (req.start) state_nxt = A_RUN;
      end
      A_RUN: begin
        if (last) state_nxt = (op_r == OP_DIV) ? A_FIX : A_IDLE;
      end
      A_FIX:   state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_comb begin
    op_nxt   = op_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    c_nxt    = c_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    case (state_r)
      A_IDLE: begin
        if (req.start) begin
          op_nxt  = req.op;
          a_nxt   = (req.op == OP_DIV) ? lhs_mag : req.lhs;
          b_nxt   = (req.op == OP_DIV) ? rhs_mag : req.rhs;
          acc_nxt = '0;
          c_nxt   = (req.op == OP_SUB);
          neg_nxt = req.lhs[DATA_WIDTH-1] ^ req.rhs[DATA_WIDTH-1];
          cnt_nxt = '0;
        end
      end
      A_RUN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        case (op_r)
          OP_ADD, OP_SUB: begin
            acc_nxt = {sum_bit, acc_r[DATA_WIDTH-1:1]};
            a_nxt   = a_r >> 1;
            b_nxt   = b_r >> 1;
            c_nxt   = carry;
          end
          OP_MUL: begin
            if (b_r[0]) acc_nxt = acc_r + a_r;
            a_nxt = a_r << 1;
            b_nxt = b_r >> 1;
          end
          default: begin
            acc_nxt = ge ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
            a_nxt   = {a_r[DATA_WIDTH-2:0], ge};
          end
        endcase
        if (last && (op_r != OP_DIV)) done_nxt = 1'b1;
      end
      A_FIX: begin
        acc_nxt  = neg_r ? (data_t'(0) - a_r) : a_r;
        done_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    op_r  <= op_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    c_r   <= c_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

endmodule

// ===== hw/rtl/postfix_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Reverse Polish evaluator: digits push, + - * / pop two and push the result.
// Path: clear, digit and error beats go through S_DECODE and S_DONE to
//   out_tvalid; arithmetic beats also pass S_READ and S_EXEC, where the
//   bit-serial ALU handles one bit per cycle (then a sign fix for divide).
// Throughput: one beat in flight; next beat accepted once the result is
//   registered, while that result may still wait for out_tready.
// Reset (rst_n low, synchronous): stack empty, no output beat pending.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pse_pkg::IN_TDATA_W-1:0]   in_tdata,  // [7:0] token
  input  logic                             in_tuser,  // [0] kind (1 = clear)
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pse_pkg::OUT_TDATA_W-1:0]  out_tdata  // [31:0] top_value,
                                                      // [37:32] stack_depth,
                                                      // [40:38] status
);
  import pse_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       kind_r, kind_nxt;
  logic [7:0] tok_r, tok_nxt;
  logic [PTR_W-1:0] sp_r, sp_nxt;
  data_t      top_r, top_nxt;
  status_t    status_r, status_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  data_t      mem [STACK_DEPTH];
  data_t      rd_data_r;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  data_t      wr_data;
  logic       wr_en;

  alu_req_t   alu_req;
  alu_rsp_t   alu_rsp;

  logic [7:0] digit;
  logic       go_alu;
  logic       out_load;
  logic signed [TOP_W-1:0] top_out;

  assign digit  = tok_r - CH_0;
  assign go_alu = !kind_r && is_op(tok_r) && (sp_r >= PTR_W'(2)) &&
                  !((op_of(tok_r) == OP_DIV) && (top_r == '0));
  assign top_out = (sp_r == '0) ? '0 : TOP_W'($signed(top_r));

  pse_serial_alu u_alu (
    .clk (clk),
    .rst_n (rst_n),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DECODE;
      end
      S_DECODE: state_nxt = go_alu ? S_READ : S_DONE;
      S_READ:   state_nxt = S_EXEC;
      S_EXEC: begin
        if (alu_rsp.done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt       = kind_r;
    tok_nxt        = tok_r;
    sp_nxt         = sp_r;
    top_nxt        = top_r;
    status_nxt     = status_r;
    wr_en          = 1'b0;
    wr_addr        = sp_r[ADDR_W-1:0];
    wr_data        = DATA_WIDTH'(digit);
    rd_addr        = ADDR_W'(sp_r - PTR_W'(2));
    alu_req.start  = 1'b0;
    alu_req.op     = op_of(tok_r);
    alu_req.lhs    = rd_data_r;
    alu_req.rhs    = top_r;
    out_load       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt   = in_tuser;
          tok_nxt    = in_tdata;
          status_nxt = ST_OK;
        end
      end
      S_DECODE: begin
        if (kind_r) begin
          sp_nxt = '0;
        end else if (is_digit(tok_r)) begin
          if (sp_r >= PTR_W'(STACK_DEPTH)) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            wr_en   = 1'b1;
            top_nxt = DATA_WIDTH'(digit);
            sp_nxt  = sp_r + PTR_W'(1);
          end
        end else if (is_op(tok_r)) begin
          if (sp_r < PTR_W'(2)) status_nxt = ST_UNDERFLOW;
          else if (!go_alu)     status_nxt = ST_DIVZERO;
        end else begin
          status_nxt = ST_UNKNOWN;
        end
      end
      S_READ: alu_req.start = 1'b1;
      S_EXEC: begin
        if (alu_rsp.done) begin
          wr_en   = 1'b1;
          wr_addr = ADDR_W'(sp_r - PTR_W'(2));
          wr_data = alu_rsp.result;
          top_nxt = alu_rsp.result;
          sp_nxt  = sp_r - PTR_W'(1);
        end
      end
      S_DONE: out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);
  assign out_data_nxt  = out_load ?
                         {{OUT_PAD_W{1'b0}}, status_r, DEPTH_W'(sp_r), top_out} :
                         out_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r     <= kind_nxt;
    tok_r      <= tok_nxt;
    top_r      <= top_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/pse_port_checker.sv =====
// ----------------------------------------------------------------------------
// pse_port_checker
// Port-level checks for the postfix stack evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pse_port_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pse_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import pse_pkg::*;

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  // one beat in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[37:32] <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth above capacity");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[37:32] == '0) |-> out_tdata[31:0] == '0)
    else $error("nonzero top on empty stack");

  a_status_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[40:38] <= ST_UNKNOWN) && (out_tdata[47:41] == '0))
    else $error("bad status code or pad bits");

endmodule

bind postfix_stack_evaluator pse_port_checker u_pse_port_checker (.*);
